// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, command codes and the
// result record of the shared subtract unit. Depends on nothing.

package rau_pkg;

  // Input numerator width; denominators are one bit narrower and unsigned.
  localparam int NW  = 16;
  localparam int DW  = NW - 1;
  // Width of the shared subtract unit (one extra bit for the division trial).
  localparam int AW  = DW + 1;
  // Full product width of the shared multiplier.
  localparam int PW  = 2 * NW;
  // Result field widths.
  localparam int RNW = 34;
  localparam int RDW = 32;
  // Shift count for common factors of two, and division step counter.
  localparam int KW  = $clog2(DW + 1);
  localparam int CW  = $clog2(DW);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_NE  = 3'd5,
    CMD_GE  = 3'd6,
    CMD_LE  = 3'd7
  } rau_cmd_t;

  // Outputs of the shared subtract unit.
  typedef struct packed {
    logic [AW-1:0] diff;    // a - b, modulo 2**AW
    logic [AW-1:0] mag;     // |a - b|
    logic          borrow;  // a < b
    logic          zero;    // a == b
  } rau_alu_res_t;

endpackage

// ===== hdl/rau_chan_if.sv =====
// Handshake channels of the rational arithmetic unit: the request channel
// and the result channel. Depends on rau_pkg.

interface rau_in_if;
  import rau_pkg::*;

  logic                 valid;
  logic                 ready;
  rau_cmd_t             cmd;
  logic signed [NW-1:0] a_num;
  logic [DW-1:0]        a_den;
  logic signed [NW-1:0] b_num;
  logic [DW-1:0]        b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [RNW-1:0] res_num;
  logic signed [RDW-1:0] res_den;
  logic                  cmp_true;
  logic                  bad_den;

  modport source (output valid, res_num, res_den, cmp_true, bad_den, input ready);
  modport sink   (input valid, res_num, res_den, cmp_true, bad_den, output ready);
endinterface

// ===== hdl/rational_arith_unit_top.sv =====
// Top level of the rational arithmetic unit: sequencer, operand registers and
// result register. Depends on rau_pkg, rau_chan_if, rau_alu and rau_mul.
//
//   Channel   Direction  Carries
//   in_chan   sink       cmd, a_num, a_den, b_num, b_den
//   out_chan  source     res_num, res_den, cmp_true, bad_den
//
// One request at a time; in_chan.ready is high only while the sequencer idles.
// Multiply and divide make two passes through the multiplier.
// Add, subtract and compares run G binary gcd steps (at most 30) and a final
// equality check on the shared subtract unit, two 15-step divisions by the gcd
// on the same unit, and three passes through the multiplier.
// A zero denominator on add, subtract or compare goes straight to the done state.
// A finished result waits in the output register while out_chan.ready is low;
// the next request is taken meanwhile and holds in its last step if needed.
// Reset is synchronous and clears the sequencer and the output valid.

module rational_arith_unit_top (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_chan,
  rau_out_if.source out_chan
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_DIVA,
    S_DIVB,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DONE
  } state_t;

  state_t                state_r;
  rau_cmd_t              cmd_r;
  logic signed [NW-1:0]  an_r, bn_r;
  logic [DW-1:0]         ad_r, bd_r;
  logic [DW-1:0]         gx_r, gy_r, g_r, rem_r, dvd_r, qa_r;
  logic [KW-1:0]         gk_r;
  logic [CW-1:0]         cnt_r;
  logic signed [PW-1:0]  p0_r, p1_r, p2_r;
  logic                  bad_r;

  logic                  out_valid_r;
  logic signed [RNW-1:0] res_num_r;
  logic signed [RDW-1:0] res_den_r;
  logic                  cmp_r, bad_out_r;

  logic                  in_fire, out_fire, prod_cmd, den_zero, res_load;
  logic [AW-1:0]         alu_a, alu_b;
  rau_alu_res_t          alu_res;
  logic signed [NW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod;

  logic [DW-1:0]         gx_nxt, gy_nxt, g_nxt, rem_nxt, dvd_nxt;
  logic [KW-1:0]         gk_nxt;
  logic                  gcd_done, q_bit, div_last;

  logic signed [RNW-1:0] sa, sb, addend, sum;
  logic                  sub_mode, eq, lt;
  logic signed [RNW-1:0] res_num_nxt;
  logic signed [RDW-1:0] res_den_nxt;
  logic                  cmp_nxt;

  // Handshakes.
  assign in_chan.ready     = (state_r == S_IDLE);
  assign in_fire           = in_chan.valid && in_chan.ready;
  assign out_fire          = out_valid_r && out_chan.ready;
  assign res_load          = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.res_num  = res_num_r;
  assign out_chan.res_den  = res_den_r;
  assign out_chan.cmp_true = cmp_r;
  assign out_chan.bad_den  = bad_out_r;

  assign prod_cmd = (in_chan.cmd == CMD_MUL) || (in_chan.cmd == CMD_DIV);
  assign den_zero = (in_chan.a_den == '0) || (in_chan.b_den == '0);

  // Operands of the shared subtract unit: gcd pair or division trial.
  always_comb begin
    if (state_r == S_GCD) begin
      alu_a = {1'b0, gx_r};
      alu_b = {1'b0, gy_r};
    end else begin
      alu_a = {rem_r, dvd_r[DW-1]};
      alu_b = {1'b0, g_r};
    end
  end

  rau_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // One binary gcd step: strip common twos, strip twos, or halve the difference.
  always_comb begin
    gx_nxt   = gx_r;
    gy_nxt   = gy_r;
    gk_nxt   = gk_r;
    gcd_done = gx_r[0] && gy_r[0] && alu_res.zero;
    priority if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1;
      gy_nxt = gy_r >> 1;
      gk_nxt = gk_r + KW'(1);
    end else if (!gx_r[0]) begin
      gx_nxt = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_nxt = gy_r >> 1;
    end else if (!alu_res.borrow) begin
      gx_nxt = alu_res.mag[DW-1:0] >> 1;
    end else begin
      gy_nxt = alu_res.mag[DW-1:0] >> 1;
    end
    g_nxt = gx_r << gk_r;
  end

  // One restoring division step by the gcd.
  always_comb begin
    q_bit    = !alu_res.borrow;
    rem_nxt  = q_bit ? alu_res.diff[DW-1:0] : alu_a[DW-1:0];
    dvd_nxt  = {dvd_r[DW-2:0], q_bit};
    div_last = (cnt_r == CW'(DW - 1));
  end

  // Multiplier operands for each pass; dvd_r holds b_den / gcd after division.
  always_comb begin
    unique case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        if (cmd_r == CMD_MUL) begin
          mul_b = bn_r;
        end else if (cmd_r == CMD_DIV) begin
          mul_b = NW'($signed({1'b0, bd_r}));
        end else begin
          mul_b = NW'($signed({1'b0, dvd_r}));
        end
      end
      S_MUL1: begin
        if (cmd_r == CMD_MUL) begin
          mul_a = NW'($signed({1'b0, ad_r}));
          mul_b = NW'($signed({1'b0, bd_r}));
        end else if (cmd_r == CMD_DIV) begin
          mul_a = NW'($signed({1'b0, ad_r}));
          mul_b = bn_r;
        end else begin
          mul_a = bn_r;
          mul_b = NW'($signed({1'b0, qa_r}));
        end
      end
      default: begin
        mul_a = NW'($signed({1'b0, qa_r}));
        mul_b = NW'($signed({1'b0, bd_r}));
      end
    endcase
  end

  rau_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Final add, subtract or compare of scaled numerators, or product pass-through.
  always_comb begin
    sa       = RNW'(p0_r);
    sb       = RNW'(p1_r);
    sub_mode = (cmd_r != CMD_ADD);
    addend   = sub_mode ? ~sb : sb;
    sum      = sa + addend + RNW'(sub_mode);
    eq       = (p0_r == p1_r);
    lt       = sum[RNW-1];
    res_num_nxt = '0;
    res_den_nxt = '0;
    cmp_nxt     = 1'b0;
    unique case (cmd_r)
      CMD_ADD, CMD_SUB: begin
        res_num_nxt = sum;
        res_den_nxt = RDW'(p2_r);
      end
      CMD_MUL, CMD_DIV: begin
        res_num_nxt = sa;
        res_den_nxt = RDW'(p1_r);
      end
      CMD_EQ:  cmp_nxt = eq;
      CMD_NE:  cmp_nxt = !eq;
      CMD_GE:  cmp_nxt = !lt;
      CMD_LE:  cmp_nxt = lt || eq;
      default: cmp_nxt = 1'b0;
    endcase
    if (bad_r) begin
      res_num_nxt = '0;
      res_den_nxt = '0;
      cmp_nxt     = 1'b0;
    end
  end

  // Sequencer, working registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_chan.cmd;
            an_r  <= in_chan.a_num;
            ad_r  <= in_chan.a_den;
            bn_r  <= in_chan.b_num;
            bd_r  <= in_chan.b_den;
            gx_r  <= in_chan.a_den;
            gy_r  <= in_chan.b_den;
            gk_r  <= '0;
            bad_r <= !prod_cmd && den_zero;
            if (prod_cmd) begin
              state_r <= S_MUL0;
            end else if (den_zero) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g_r     <= g_nxt;
            rem_r   <= '0;
            dvd_r   <= ad_r;
            cnt_r   <= '0;
            state_r <= S_DIVA;
          end else begin
            gx_r <= gx_nxt;
            gy_r <= gy_nxt;
            gk_r <= gk_nxt;
          end
        end
        S_DIVA: begin
          if (div_last) begin
            qa_r    <= dvd_nxt;
            rem_r   <= '0;
            dvd_r   <= bd_r;
            cnt_r   <= '0;
            state_r <= S_DIVB;
          end else begin
            rem_r <= rem_nxt;
            dvd_r <= dvd_nxt;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_DIVB: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (div_last) begin
            state_r <= S_MUL0;
          end
        end
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: begin
          p0_r    <= prod;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p1_r <= prod;
          if ((cmd_r == CMD_MUL) || (cmd_r == CMD_DIV)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL3;
          end
        end
        S_MUL3: begin
          p2_r    <= prod;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            res_num_r <= res_num_nxt;
            res_den_r <= res_den_nxt;
            cmp_r     <= cmp_nxt;
            bad_out_r <= bad_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // An accepted request always leaves the idle state.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after a request");

  // A denominator error carries an all-zero result.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_out_r) |-> (res_num_r == '0 && res_den_r == '0 && !cmp_r))
    else $error("error result carries nonzero fields");

  // The gcd operands never reach zero.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> (gx_r != '0 && gy_r != '0))
    else $error("gcd operand became zero");

  // The partial remainder stays below the divisor.
  a_rem_below_g: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVA || state_r == S_DIVB) |-> rem_r < g_r)
    else $error("division remainder not below gcd");

endmodule

// ===== hdl/rau_alu.sv =====
// Shared subtract and compare unit, used for the binary gcd steps and the
// restoring division steps. Depends on rau_pkg.

module rau_alu (
  input  logic [rau_pkg::AW-1:0] a,
  input  logic [rau_pkg::AW-1:0] b,
  output rau_pkg::rau_alu_res_t  res
);
  import rau_pkg::*;

  logic [AW:0] d;

  // One wide subtract gives difference, borrow and equality.
  always_comb begin
    d          = {1'b0, a} - {1'b0, b};
    res.diff   = d[AW-1:0];
    res.borrow = d[AW];
    res.zero   = (d[AW-1:0] == '0);
    res.mag    = d[AW] ? (b - a) : d[AW-1:0];
  end

endmodule

// ===== hdl/rau_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on rau_pkg.

module rau_mul (
  input  logic                         clk,
  input  logic signed [rau_pkg::NW-1:0] op_a,
  input  logic signed [rau_pkg::NW-1:0] op_b,
  output logic signed [rau_pkg::PW-1:0] prod
);
  import rau_pkg::*;

  logic signed [PW-1:0] prod_r;

  // The product is registered before anything else uses it.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
